>>> rtl/tvsw_pkg.sv
// tvsw_pkg: shared types and constants of the teleop velocity shaper.
// Holds the sequencer state type, register indexes and fixed field widths.
// No dependencies.
package tvsw_pkg;

  localparam int AXIS_BITS_DEF = 16;

  localparam int GAIN_W   = 16;
  localparam int GAIN_FRAC = 14;
  localparam int OUT_FRAC = 12;
  localparam int LLIM_W   = 15;
  localparam int ALIM_W   = 16;
  localparam int TICK_W   = 14;
  localparam int LCMD_W   = 16;
  localparam int ACMD_W   = 17;
  localparam int CMP_W    = 18;   // signed compare width for the clamp
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEADMAN_REQ     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_GAIN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS   = 3'd5;

  localparam logic [LLIM_W-1:0] LLIM_RST    = 15'd4096;
  localparam logic [ALIM_W-1:0] ALIM_RST    = 16'd4096;
  localparam logic [GAIN_W-1:0] GAIN_RST    = 16'd16384;
  localparam logic [TICK_W-1:0] TIMEOUT_RST = 14'd500;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GT,    // gain * throttle
    S_HI,    // axis * upper half of gain*throttle
    S_LO,    // axis * lower half
    S_FIN,   // accumulate, floor, clamp
    S_DONE   // result waits for the output register
  } state_t;

endpackage

>>> rtl/tvsw_mul.sv
// tvsw_mul: shared signed-by-unsigned multiplier with a registered product.
// Used by the sequencer in the top level; depends on nothing else.
module tvsw_mul #(
  parameter int AW = 17,
  parameter int BW = 16
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic        [BW-1:0] b,
  output logic signed [AW+BW:0] prod
);

  logic signed [AW+BW:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * $signed({1'b0, b});
  end

  assign prod = prod_r;

endmodule

>>> rtl/teleop_velocity_shaper_watchdog.sv
// Teleop velocity shaper with deadman check and tick watchdog.
// Channels: in_* carries either a joystick sample (in_mode 0) or a timer tick
// (in_mode 1); out_* carries velocity commands; cfg_* writes the six
// registers (deadman requirement, linear/angular limit, linear/angular gain,
// timeout_ticks) and is always ready. Write configuration only while idle.
// A sample always yields one command. With the deadman required and not held
// the sample goes straight to S_DONE; otherwise each axis takes four
// sequencer steps around the single shared multiplier
// (gain*throttle, axis*upper half, axis*lower half, then add/floor/clamp),
// and S_DONE then moves the result into the output register.
// in_stall is high from acceptance until the result moves into the output
// register, so no new sample is taken before the previous result is in the
// output register, on the deadman path as well.
// A tick that leaves the watchdog untripped keeps the block idle; one that
// trips it queues a zero command with out_watchdog_stop set in S_DONE, with input stalled.
// A stalled out_* holds its item; the next result waits internally, with
// in_stall high, until the output register frees.
// Reset (rst_n low, synchronous) clears the tick counter, the fired flag and
// out_valid, and loads the register defaults.
module teleop_velocity_shaper_watchdog import tvsw_pkg::*; #(
  parameter int AXIS_BITS = AXIS_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic signed [AXIS_BITS-1:0] in_linear_axis,
  input  logic                        in_linear_present,
  input  logic signed [AXIS_BITS-1:0] in_angular_axis,
  input  logic                        in_angular_present,
  input  logic signed [AXIS_BITS-1:0] in_throttle_axis,
  input  logic                        in_throttle_present,
  input  logic                        in_deadman_held,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [LCMD_W-1:0]    out_linear_cmd,
  output logic signed [ACMD_W-1:0]    out_angular_cmd,
  output logic                        out_deadman_state,
  output logic                        out_watchdog_stop,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int AW  = ((AXIS_BITS > GAIN_W) ? AXIS_BITS : GAIN_W) + 1;
  localparam int GTW = AXIS_BITS + GAIN_W;           // gain * throttle
  localparam int HW  = (GTW + 1) / 2;                // low half of it
  localparam int BW  = (AXIS_BITS > HW) ? AXIS_BITS : HW;
  localparam int PRW = AW + BW + 1;
  localparam int PW  = 2 * AXIS_BITS + GAIN_W + 1;   // full product
  localparam int SH  = 2 * (AXIS_BITS - 1) + GAIN_FRAC - OUT_FRAC;

  localparam logic [AXIS_BITS:0] ONE_W = (AXIS_BITS+1)'(1) << (AXIS_BITS - 1);

  // configuration registers
  logic              cfg_req_dm_r;
  logic [LLIM_W-1:0] cfg_llim_r;
  logic [ALIM_W-1:0] cfg_alim_r;
  logic [GAIN_W-1:0] cfg_lgain_r;
  logic [GAIN_W-1:0] cfg_again_r;
  logic [TICK_W-1:0] cfg_timeout_r;

  state_t state_r, state_nxt;
  logic                        axis_sel_r, axis_sel_nxt;
  logic signed [AXIS_BITS-1:0] lin_ax_r, lin_ax_nxt;
  logic signed [AXIS_BITS-1:0] ang_ax_r, ang_ax_nxt;
  logic [AXIS_BITS-1:0]        thr_r, thr_nxt;
  logic [HW-1:0]               gt_lo_r, gt_lo_nxt;
  logic signed [PW-1:0]        acc_r, acc_nxt;
  logic signed [LCMD_W-1:0]    res_lin_r, res_lin_nxt;
  logic signed [ACMD_W-1:0]    res_ang_r, res_ang_nxt;
  logic                        res_dm_r, res_dm_nxt;
  logic                        res_wd_r, res_wd_nxt;
  logic [TICK_W-1:0]           ticks_r, ticks_nxt;
  logic                        fired_r, fired_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic signed [LCMD_W-1:0]    out_lin_r, out_lin_nxt;
  logic signed [ACMD_W-1:0]    out_ang_r, out_ang_nxt;
  logic                        out_dm_r, out_dm_nxt;
  logic                        out_wd_r, out_wd_nxt;

  logic signed [AW-1:0]  mul_a;
  logic [BW-1:0]         mul_b;
  logic signed [PRW-1:0] prod;

  logic                  in_acc;
  logic [AXIS_BITS:0]    thr_diff;
  logic [AXIS_BITS-1:0]  thr_in;
  logic [TICK_W-1:0]     ticks_inc;
  logic signed [PW-1:0]  sum;
  logic signed [CMP_W-1:0] q, lim, nlim, qc;
  logic signed [AXIS_BITS-1:0] cur_ax;

  tvsw_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_req_dm_r  <= 1'b1;
      cfg_llim_r    <= LLIM_RST;
      cfg_alim_r    <= ALIM_RST;
      cfg_lgain_r   <= GAIN_RST;
      cfg_again_r   <= GAIN_RST;
      cfg_timeout_r <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEADMAN_REQ:     cfg_req_dm_r  <= cfg_data[0];
        CFG_LINEAR_LIMIT:    cfg_llim_r    <= cfg_data[LLIM_W-1:0];
        CFG_ANGULAR_LIMIT:   cfg_alim_r    <= cfg_data[ALIM_W-1:0];
        CFG_LINEAR_GAIN:     cfg_lgain_r   <= cfg_data[GAIN_W-1:0];
        CFG_ANGULAR_GAIN:    cfg_again_r   <= cfg_data[GAIN_W-1:0];
        CFG_TIMEOUT_TICKS:   cfg_timeout_r <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_sel_r  <= 1'b0;
      ticks_r     <= '0;
      fired_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_sel_r  <= axis_sel_nxt;
      ticks_r     <= ticks_nxt;
      fired_r     <= fired_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lin_ax_r  <= lin_ax_nxt;
    ang_ax_r  <= ang_ax_nxt;
    thr_r     <= thr_nxt;
    gt_lo_r   <= gt_lo_nxt;
    acc_r     <= acc_nxt;
    res_lin_r <= res_lin_nxt;
    res_ang_r <= res_ang_nxt;
    res_dm_r  <= res_dm_nxt;
    res_wd_r  <= res_wd_nxt;
    out_lin_r <= out_lin_nxt;
    out_ang_r <= out_ang_nxt;
    out_dm_r  <= out_dm_nxt;
    out_wd_r  <= out_wd_nxt;
  end

  // throttle = (one - t) / 2, never negative so the shift floors
  assign thr_diff  = ONE_W - {in_throttle_axis[AXIS_BITS-1], in_throttle_axis};
  assign thr_in    = in_throttle_present ? thr_diff[AXIS_BITS:1] : ONE_W[AXIS_BITS-1:0];
  assign ticks_inc = (ticks_r == TICK_MAX) ? ticks_r : ticks_r + 1'b1;
  assign cur_ax    = axis_sel_r ? ang_ax_r : lin_ax_r;

  // arithmetic shift floors toward minus infinity
  assign sum  = acc_r + PW'(prod);
  assign q    = CMP_W'($signed(sum[PW-1:SH]));
  assign lim  = axis_sel_r ? $signed(CMP_W'(cfg_alim_r)) : $signed(CMP_W'(cfg_llim_r));
  assign nlim = -lim;
  assign qc   = (q > lim) ? lim : ((q < nlim) ? nlim : q);

  always_comb begin
    state_nxt    = state_r;
    axis_sel_nxt = axis_sel_r;
    lin_ax_nxt   = lin_ax_r;
    ang_ax_nxt   = ang_ax_r;
    thr_nxt      = thr_r;
    gt_lo_nxt    = gt_lo_r;
    acc_nxt      = acc_r;
    res_lin_nxt  = res_lin_r;
    res_ang_nxt  = res_ang_r;
    res_dm_nxt   = res_dm_r;
    res_wd_nxt   = res_wd_r;
    ticks_nxt    = ticks_r;
    fired_nxt    = fired_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_lin_nxt  = out_lin_r;
    out_ang_nxt  = out_ang_r;
    out_dm_nxt   = out_dm_r;
    out_wd_nxt   = out_wd_r;
    mul_a        = AW'(cur_ax);
    mul_b        = BW'(gt_lo_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_mode) begin
            ticks_nxt = ticks_inc;
            if (ticks_inc > cfg_timeout_r && !fired_r) begin
              fired_nxt   = 1'b1;
              res_lin_nxt = '0;
              res_ang_nxt = '0;
              res_dm_nxt  = 1'b0;
              res_wd_nxt  = 1'b1;
              state_nxt   = S_DONE;
            end
          end else begin
            ticks_nxt    = '0;
            fired_nxt    = 1'b0;
            res_dm_nxt   = in_deadman_held;
            res_wd_nxt   = 1'b0;
            lin_ax_nxt   = in_linear_present ? in_linear_axis : '0;
            ang_ax_nxt   = in_angular_present ? in_angular_axis : '0;
            thr_nxt      = thr_in;
            axis_sel_nxt = 1'b0;
            if (cfg_req_dm_r && !in_deadman_held) begin
              res_lin_nxt = '0;
              res_ang_nxt = '0;
              state_nxt   = S_DONE;
            end else begin
              state_nxt = S_GT;
            end
          end
        end
      end
      S_GT: begin
        mul_a     = $signed(AW'(axis_sel_r ? cfg_again_r : cfg_lgain_r));
        mul_b     = BW'(thr_r);
        state_nxt = S_HI;
      end
      S_HI: begin
        mul_a     = AW'(cur_ax);
        mul_b     = BW'(prod[GTW-1:HW]);
        gt_lo_nxt = prod[HW-1:0];
        state_nxt = S_LO;
      end
      S_LO: begin
        mul_a     = AW'(cur_ax);
        mul_b     = BW'(gt_lo_r);
        acc_nxt   = PW'(prod) <<< HW;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (axis_sel_r) begin
          res_ang_nxt = qc[ACMD_W-1:0];
          state_nxt   = S_DONE;
        end else begin
          res_lin_nxt  = qc[LCMD_W-1:0];
          axis_sel_nxt = 1'b1;
          state_nxt    = S_GT;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_lin_nxt   = res_lin_r;
          out_ang_nxt   = res_ang_r;
          out_dm_nxt    = res_dm_r;
          out_wd_nxt    = res_wd_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_linear_cmd     = out_lin_r;
  assign out_angular_cmd    = out_ang_r;
  assign out_deadman_state  = out_dm_r;
  assign out_watchdog_stop  = out_wd_r;

endmodule

>>> rtl/tvsw_checker.sv
// tvsw_checker: port-level assertions for the teleop velocity shaper,
// bound to the top level below. Depends on teleop_velocity_shaper_watchdog.
module tvsw_checker import tvsw_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     in_mode,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [LCMD_W-1:0] out_linear_cmd,
  input logic signed [ACMD_W-1:0] out_angular_cmd,
  input logic                     out_deadman_state,
  input logic                     out_watchdog_stop
);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_linear_cmd)
      && $stable(out_angular_cmd) && $stable(out_deadman_state)
      && $stable(out_watchdog_stop))
    else $error("stalled output item changed");

  a_wd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_watchdog_stop |-> out_linear_cmd == '0
      && out_angular_cmd == '0 && !out_deadman_state)
    else $error("watchdog item carries non-zero fields");

  // an accepted sample always raises in_stall, also on the deadman path that skips the multiplier
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_mode |=> in_stall)
    else $error("input taken again right after a sample");

  a_rst_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind teleop_velocity_shaper_watchdog tvsw_checker u_tvsw_checker (.*);
